// ===== rtl/vertex_attribute_to_float_macros.svh =====
// Assertion macros used by the vertex attribute converter top level.
`ifndef VERTEX_ATTRIBUTE_TO_FLOAT_MACROS_SVH
`define VERTEX_ATTRIBUTE_TO_FLOAT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VAF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vaf: implication check failed");

// Next-cycle implication, checked out of reset.
`define VAF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vaf: next-cycle check failed");

`endif

// ===== rtl/vaf_pkg.sv =====
// Shared types, codes and constants of the vertex attribute converter.
`default_nettype none
package vaf_pkg;

    // Data format codes
    localparam logic [3:0] FMT_BYTE   = 4'd0;
    localparam logic [3:0] FMT_UBYTE  = 4'd1;
    localparam logic [3:0] FMT_SHORT  = 4'd2;
    localparam logic [3:0] FMT_USHORT = 4'd3;
    localparam logic [3:0] FMT_INT    = 4'd4;
    localparam logic [3:0] FMT_UINT   = 4'd5;
    localparam logic [3:0] FMT_FLOAT  = 4'd6;
    localparam logic [3:0] FMT_DOUBLE = 4'd7;
    localparam logic [3:0] FMT_HALF   = 4'd8;

    // Register indexes
    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_FORMAT = 2'd1;
    localparam logic [1:0] REG_NORM   = 2'd2;
    localparam logic [1:0] REG_PAD    = 2'd3;

    localparam int NUM_STAGES = 5;

    typedef struct packed {
        logic [2:0]  count;
        logic [3:0]  fmt;
        logic        norm;
        logic [31:0] pad;
    } cfg_t;

    // float32 reciprocal of the integer format's maximum
    function automatic logic [31:0] recip_bits(input logic [3:0] fmt);
        logic [31:0] r;
        case (fmt)
            FMT_BYTE:   r = 32'h3C01_0204;
            FMT_UBYTE:  r = 32'h3B80_8081;
            FMT_SHORT:  r = 32'h3800_0100;
            FMT_USHORT: r = 32'h3780_0080;
            FMT_INT:    r = 32'h3000_0000;
            FMT_UINT:   r = 32'h2F80_0000;
            default:    r = 32'h3F80_0000;
        endcase
        return r;
    endfunction

    // leading zero count of a 32-bit word (32 when zero)
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vaf_cfg_regs.sv =====
// APB-style configuration registers of the vertex attribute converter.
`default_nettype none
module vaf_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output vaf_pkg::cfg_t     cfg
);

    logic [2:0]  count_reg;
    logic [3:0]  fmt_reg;
    logic        norm_reg;
    logic [31:0] pad_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= 3'd4;
            fmt_reg   <= vaf_pkg::FMT_FLOAT;
            norm_reg  <= 1'b0;
            pad_reg   <= 32'h3F80_0000;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                vaf_pkg::REG_COUNT:  count_reg <= pwdata[2:0];
                vaf_pkg::REG_FORMAT: fmt_reg   <= pwdata[3:0];
                vaf_pkg::REG_NORM:   norm_reg  <= pwdata[0];
                vaf_pkg::REG_PAD:    pad_reg   <= pwdata;
                default:             count_reg <= count_reg;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            vaf_pkg::REG_COUNT:  prdata = {29'd0, count_reg};
            vaf_pkg::REG_FORMAT: prdata = {28'd0, fmt_reg};
            vaf_pkg::REG_NORM:   prdata = {31'd0, norm_reg};
            vaf_pkg::REG_PAD:    prdata = pad_reg;
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.count = count_reg;
    assign cfg.fmt   = fmt_reg;
    assign cfg.norm  = norm_reg;
    assign cfg.pad   = pad_reg;

endmodule
`default_nettype wire

// ===== rtl/vaf_lane.sv =====
// Five-stage conversion pipeline for one attribute component.
`default_nettype none
module vaf_lane (
    input  wire logic          clk,
    input  wire vaf_pkg::cfg_t cfg,
    input  wire logic [vaf_pkg::NUM_STAGES-1:0] en,
    input  wire logic          pad_sel,
    input  wire logic [63:0]   raw,
    output logic [31:0]        res
);

    // ---------------- stage 1: decode ----------------
    logic        is_int;
    logic        sign1_next, sign1_reg;
    logic [31:0] mag1_next, mag1_reg;
    logic [31:0] dir1_next, dir1_reg;
    logic        dfin1_next, dfin1_reg;
    logic [23:0] dq1_next, dq1_reg;
    logic        dg1_next, dg1_reg;
    logic        dst1_next, dst1_reg;
    logic [7:0]  dbase1_next, dbase1_reg;
    logic        ds1_next, ds1_reg;

    // half fields
    logic [4:0]  h_e;
    logic [9:0]  h_m;
    logic [5:0]  h_lz;
    logic [9:0]  h_mn;
    logic [7:0]  h_fe;
    logic [31:0] half_res;

    // double fields
    logic [10:0]        d_e;
    logic [51:0]        d_m;
    logic [52:0]        d_sig;
    logic signed [12:0] d_fe;
    logic [5:0]         d_sh;
    logic [52:0]        d_q;
    logic [52:0]        d_gv;
    logic [52:0]        d_mask;

    assign is_int = (cfg.fmt <= vaf_pkg::FMT_UINT);

    always_comb begin
        // integer sign and magnitude
        sign1_next = 1'b0;
        mag1_next  = 32'd0;
        case (cfg.fmt)
            vaf_pkg::FMT_BYTE: begin
                sign1_next = raw[7];
                mag1_next  = raw[7] ? {24'd0, 8'(~raw[7:0] + 8'd1)} : {24'd0, raw[7:0]};
            end
            vaf_pkg::FMT_UBYTE:  mag1_next = {24'd0, raw[7:0]};
            vaf_pkg::FMT_SHORT: begin
                sign1_next = raw[15];
                mag1_next  = raw[15] ? {16'd0, 16'(~raw[15:0] + 16'd1)}
                                     : {16'd0, raw[15:0]};
            end
            vaf_pkg::FMT_USHORT: mag1_next = {16'd0, raw[15:0]};
            vaf_pkg::FMT_INT: begin
                sign1_next = raw[31];
                mag1_next  = raw[31] ? 32'(~raw[31:0] + 32'd1) : raw[31:0];
            end
            vaf_pkg::FMT_UINT:   mag1_next = raw[31:0];
            default: begin
                sign1_next = 1'b0;
                mag1_next  = 32'd0;
            end
        endcase

        // half to single, exact
        h_e  = raw[14:10];
        h_m  = raw[9:0];
        h_lz = vaf_pkg::lzc32({h_m, 22'd0});
        h_mn = 10'({h_m, 1'b0} << h_lz);
        h_fe = 8'(8'd112 - {2'd0, h_lz});
        if (h_e == 5'd31) begin
            half_res = {raw[15], 8'hFF, h_m, 13'd0};
        end else if (h_e == 5'd0) begin
            half_res = (h_m == 10'd0) ? {raw[15], 31'd0} : {raw[15], h_fe, h_mn, 13'd0};
        end else begin
            half_res = {raw[15], 8'(8'd112 + {3'd0, h_e}), h_m, 13'd0};
        end

        // double to single: specials, shift and round bits
        d_e    = raw[62:52];
        d_m    = raw[51:0];
        d_sig  = {1'b1, d_m};
        d_fe   = $signed({2'b00, d_e}) - 13'sd896;
        d_sh   = (d_fe >= 13'sd1) ? 6'd29 : 6'(13'sd30 - d_fe);
        d_q    = d_sig >> d_sh;
        d_gv   = d_sig >> (d_sh - 6'd1);
        d_mask = 53'((64'd1 << (d_sh - 6'd1)) - 64'd1);
        dq1_next    = d_q[23:0];
        dg1_next    = d_gv[0];
        dst1_next   = |(d_sig & d_mask);
        dbase1_next = (d_fe >= 13'sd1) ? 8'(d_fe - 13'sd1) : 8'd0;
        ds1_next    = raw[63];

        // results that need no further work
        dfin1_next = 1'b1;
        case (cfg.fmt)
            vaf_pkg::FMT_FLOAT: dir1_next = raw[31:0];
            vaf_pkg::FMT_HALF:  dir1_next = half_res;
            vaf_pkg::FMT_DOUBLE: begin
                if (d_e == 11'h7FF) begin
                    dir1_next = (d_m != 52'd0) ? {raw[63], 9'h1FF, d_m[50:29]}
                                               : {raw[63], 8'hFF, 23'd0};
                end else if (d_e == 11'd0 || d_fe < -13'sd31) begin
                    dir1_next = {raw[63], 31'd0};
                end else if (d_fe >= 13'sd255) begin
                    dir1_next = {raw[63], 8'hFF, 23'd0};
                end else begin
                    dir1_next  = 32'd0;
                    dfin1_next = 1'b0;
                end
            end
            default: dir1_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk) begin
        if (en[0]) begin
            sign1_reg  <= sign1_next;
            mag1_reg   <= mag1_next;
            dir1_reg   <= dir1_next;
            dfin1_reg  <= dfin1_next;
            dq1_reg    <= dq1_next;
            dg1_reg    <= dg1_next;
            dst1_reg   <= dst1_next;
            dbase1_reg <= dbase1_next;
            ds1_reg    <= ds1_next;
        end
    end

    // ---------------- stage 2: normalize integer, round double ----------------
    logic [5:0]  lz2;
    logic [31:0] norm2_next, norm2_reg;
    logic [4:0]  exp2_next, exp2_reg;
    logic        zero2_reg, sign2_reg;
    logic        dr2;
    logic [30:0] dsum2;
    logic [31:0] res2_next, res2_reg;

    always_comb begin
        lz2        = vaf_pkg::lzc32(mag1_reg);
        norm2_next = mag1_reg << lz2;
        exp2_next  = 5'(6'd31 - lz2);
        dr2        = dg1_reg && (dst1_reg || dq1_reg[0]);
        dsum2      = {dbase1_reg, 23'd0} + {7'd0, dq1_reg} + {30'd0, dr2};
        res2_next  = dfin1_reg ? dir1_reg : {ds1_reg, dsum2};
    end

    always_ff @(posedge clk) begin
        if (en[1]) begin
            norm2_reg <= norm2_next;
            exp2_reg  <= exp2_next;
            zero2_reg <= (mag1_reg == 32'd0);
            sign2_reg <= sign1_reg;
            res2_reg  <= res2_next;
        end
    end

    // ---------------- stage 3: round integer to float32 ----------------
    logic        r3;
    logic [24:0] sum3;
    logic [7:0]  exp3_next, exp3_reg;
    logic [23:0] man3_next, man3_reg;
    logic        zero3_reg, sign3_reg;
    logic [31:0] res3_reg;

    always_comb begin
        r3   = norm2_reg[7] && ((|norm2_reg[6:0]) || norm2_reg[8]);
        sum3 = {1'b0, norm2_reg[31:8]} + {24'd0, r3};
        if (zero2_reg) begin
            exp3_next = 8'd0;
            man3_next = 24'd0;
        end else if (sum3[24]) begin
            exp3_next = 8'(8'd128 + {3'd0, exp2_reg});
            man3_next = sum3[24:1];
        end else begin
            exp3_next = 8'(8'd127 + {3'd0, exp2_reg});
            man3_next = sum3[23:0];
        end
    end

    always_ff @(posedge clk) begin
        if (en[2]) begin
            exp3_reg  <= exp3_next;
            man3_reg  <= man3_next;
            zero3_reg <= zero2_reg;
            sign3_reg <= sign2_reg;
            res3_reg  <= res2_reg;
        end
    end

    // ---------------- stage 4: multiply by reciprocal ----------------
    logic [31:0] kbits;
    logic [23:0] kman;
    logic [47:0] prod4_reg;
    logic [9:0]  e4_reg;
    logic        zero4_reg, sign4_reg;
    logic [31:0] f4_reg;
    logic [31:0] res4_reg;

    assign kbits = vaf_pkg::recip_bits(cfg.fmt);
    assign kman  = {1'b1, kbits[22:0]};

    always_ff @(posedge clk) begin
        if (en[3]) begin
            prod4_reg <= man3_reg * kman;
            e4_reg    <= {2'd0, exp3_reg} + {2'd0, kbits[30:23]} - 10'd127;
            zero4_reg <= zero3_reg;
            sign4_reg <= sign3_reg;
            f4_reg    <= zero3_reg ? 32'd0 : {sign3_reg, exp3_reg, man3_reg[22:0]};
            res4_reg  <= res3_reg;
        end
    end

    // ---------------- stage 5: round product, select result ----------------
    logic        hi5;
    logic [23:0] m5;
    logic        g5, st5, r5;
    logic [24:0] sum5;
    logic [7:0]  e5;
    logic [31:0] mres5;
    logic [31:0] res5_next, res5_reg;

    always_comb begin
        hi5  = prod4_reg[47];
        m5   = hi5 ? prod4_reg[47:24] : prod4_reg[46:23];
        g5   = hi5 ? prod4_reg[23] : prod4_reg[22];
        st5  = hi5 ? (|prod4_reg[22:0]) : (|prod4_reg[21:0]);
        r5   = g5 && (st5 || m5[0]);
        sum5 = {1'b0, m5} + {24'd0, r5};
        e5   = 8'(e4_reg + {9'd0, hi5} + {9'd0, sum5[24]});
        mres5 = zero4_reg ? 32'd0
                          : {sign4_reg, e5, (sum5[24] ? 23'd0 : sum5[22:0])};
        if (cfg.fmt > vaf_pkg::FMT_HALF) begin
            res5_next = 32'd0;
        end else if (pad_sel) begin
            res5_next = cfg.pad;
        end else if (is_int) begin
            res5_next = cfg.norm ? mres5 : f4_reg;
        end else begin
            res5_next = res4_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en[4]) begin
            res5_reg <= res5_next;
        end
    end

    assign res = res5_reg;

endmodule
`default_nettype wire

// ===== rtl/vertex_attribute_to_float.sv =====
// Vertex attribute converter: four raw components in, four float32 words out.
//
// Use: an attribute element enters on in_valid/in_ready with raw_comp0..3 and
// last_in; the four float32 words leave on out_valid/out_ready with last_out.
// Configuration (component count, data format, normalize, pad value) must be
// written through the APB-style port while no item is in flight; the block
// does not enforce this. pready is always high. Each accepted item passes
// five registered stages to out_valid: decode, integer normalize / double
// rounding, integer rounding, reciprocal multiply, product rounding and
// output select. Throughput is one item per cycle while out_ready is high.
// Each stage holds its own valid bit and advances when the next stage is empty
// or advancing, so bubbles close up. When the receiver stalls, results stay
// in place and the input keeps accepting until all five stages are full.
// Reset (rst_n low, asynchronous) empties the pipeline and restores count 4,
// float format, normalize off and pad 1.0.
`default_nettype none
`include "vertex_attribute_to_float_macros.svh"
module vertex_attribute_to_float (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] raw_comp0,
    input  wire logic [63:0] raw_comp1,
    input  wire logic [63:0] raw_comp2,
    input  wire logic [63:0] raw_comp3,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic [31:0]      out_z,
    output logic [31:0]      out_w,
    output logic             last_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NS = vaf_pkg::NUM_STAGES;

    vaf_pkg::cfg_t  cfg;
    logic [NS-1:0]  valid_reg;
    logic [NS-1:0]  last_reg;
    logic [NS-1:0]  stage_en;
    logic           pad_z, pad_w;

    vaf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign in_ready = stage_en[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // last marker travels beside the data
    always_ff @(posedge clk) begin
        if (stage_en[0]) begin
            last_reg[0] <= last_in;
        end
        for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    // padding: counts below two act as two, above four as four
    assign pad_z = (cfg.count < 3'd3);
    assign pad_w = (cfg.count < 3'd4);

    vaf_lane u_lane_x (
        .clk(clk), .cfg(cfg), .en(stage_en), .pad_sel(1'b0), .raw(raw_comp0), .res(out_x)
    );
    vaf_lane u_lane_y (
        .clk(clk), .cfg(cfg), .en(stage_en), .pad_sel(1'b0), .raw(raw_comp1), .res(out_y)
    );
    vaf_lane u_lane_z (
        .clk(clk), .cfg(cfg), .en(stage_en), .pad_sel(pad_z), .raw(raw_comp2), .res(out_z)
    );
    vaf_lane u_lane_w (
        .clk(clk), .cfg(cfg), .en(stage_en), .pad_sel(pad_w), .raw(raw_comp3), .res(out_w)
    );

    assign out_valid = valid_reg[NS-1];
    assign last_out  = last_reg[NS-1];

    // checks
    `VAF_ASSERT_NXT(a_accept_fills_s1, in_valid && in_ready, valid_reg[0])
    `VAF_ASSERT_IMP(a_full_stall_blocks, (&valid_reg) && !out_ready, !in_ready)
    `VAF_ASSERT_NXT(a_s4_moves_to_out, stage_en[NS-1] && valid_reg[NS-2], valid_reg[NS-1])

endmodule
`default_nettype wire

// ===== tb/vaf_checker.sv =====
// Checker for the vertex attribute converter: predicts and compares every output item.
`default_nettype none
module vaf_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [63:0] raw_comp0,
    input  wire logic [63:0] raw_comp1,
    input  wire logic [63:0] raw_comp2,
    input  wire logic [63:0] raw_comp3,
    input  wire logic        last_in,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] out_x,
    input  wire logic [31:0] out_y,
    input  wire logic [31:0] out_z,
    input  wire logic [31:0] out_w,
    input  wire logic        last_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               mismatch_count,
    output int               pending_count
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        last;
    } vertex_words_t;

    vertex_words_t expected_vertices[$];

    // register shadow
    logic [2:0]  cnt_reg;
    logic [3:0]  fmt_reg;
    logic        norm_reg;
    logic [31:0] pad_reg;

    // double to float32, round to nearest even
    function automatic logic [31:0] narrow_to_single(input logic [63:0] d);
        logic [31:0] s;
        logic [10:0] e;
        logic [63:0] m, sig, q, rem, hf;
        int fe, sh;
        logic [31:0] base;
        s = {d[63], 31'b0};
        e = d[62:52];
        m = {12'b0, d[51:0]};
        if (e == 11'h7FF)
            return (m != 0) ? (s | 32'h7FC0_0000 | 32'(m >> 29)) : (s | 32'h7F80_0000);
        if (e == 0)
            return s;
        fe = int'(e) - 1023 + 127;
        if (fe >= 255)
            return s | 32'h7F80_0000;
        sig = m | (64'd1 << 52);
        if (fe >= 1) begin
            sh = 29;
            base = 32'(fe - 1) << 23;
        end
        else begin
            if (fe < -31)
                return s;
            sh = 29 + (1 - fe);
            base = 0;
        end
        q = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        hf = 64'd1 << (sh - 1);
        if (rem > hf || (rem == hf && q[0]))
            q = q + 1;
        return s | (base + q[31:0]);
    endfunction

    // float32 to double; only zero and normal values reach this
    function automatic logic [63:0] widen_single(input logic [31:0] f);
        if (f[30:0] == 0)
            return {f[31], 63'b0};
        return {f[31], {3'b0, f[30:23]} + 11'd896, f[22:0], 29'b0};
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [10:0] m;
        int fe;
        m = {1'b0, h[9:0]};
        if (h[14:10] == 5'h1F)
            return {h[15], 8'hFF, h[9:0], 13'b0};
        if (h[14:10] == 0) begin
            if (m == 0)
                return {h[15], 31'b0};
            fe = 113;
            while (!m[10]) begin
                m = m << 1;
                fe = fe - 1;
            end
            return {h[15], 8'(fe), m[9:0], 13'b0};
        end
        return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'b0};
    endfunction

    function automatic logic [31:0] scale_of(input logic [3:0] fmt);
        real r;
        case (fmt)
            vaf_pkg::FMT_BYTE:   r = 1.0 / 127.0;
            vaf_pkg::FMT_UBYTE:  r = 1.0 / 255.0;
            vaf_pkg::FMT_SHORT:  r = 1.0 / 32767.0;
            vaf_pkg::FMT_USHORT: r = 1.0 / 65535.0;
            vaf_pkg::FMT_INT:    r = 1.0 / 2147483647.0;
            default:             r = 1.0 / 4294967295.0;
        endcase
        return narrow_to_single($realtobits(r));
    endfunction

    function automatic logic [31:0] component_to_float(input logic [63:0] raw);
        longint v;
        real r;
        logic [31:0] f;
        case (fmt_reg)
            vaf_pkg::FMT_BYTE:   v = longint'($signed(raw[7:0]));
            vaf_pkg::FMT_UBYTE:  v = longint'(raw[7:0]);
            vaf_pkg::FMT_SHORT:  v = longint'($signed(raw[15:0]));
            vaf_pkg::FMT_USHORT: v = longint'(raw[15:0]);
            vaf_pkg::FMT_INT:    v = longint'($signed(raw[31:0]));
            vaf_pkg::FMT_UINT:   v = longint'(raw[31:0]);
            vaf_pkg::FMT_FLOAT:  return raw[31:0];
            vaf_pkg::FMT_DOUBLE: return narrow_to_single(raw);
            vaf_pkg::FMT_HALF:   return widen_half(raw[15:0]);
            default:             return 32'b0;
        endcase
        r = v;
        f = narrow_to_single($realtobits(r));
        // exact product in double, rounded once to float32
        if (norm_reg) begin
            r = $bitstoreal(widen_single(f)) * $bitstoreal(widen_single(scale_of(fmt_reg)));
            f = narrow_to_single($realtobits(r));
        end
        return f;
    endfunction

    function automatic vertex_words_t convert_vertex(input logic [63:0] c0, input logic [63:0] c1,
                                                     input logic [63:0] c2, input logic [63:0] c3,
                                                     input logic lst);
        vertex_words_t vw;
        int n;
        n = (cnt_reg < 2) ? 2 : (cnt_reg > 4) ? 4 : int'(cnt_reg);
        vw.x = component_to_float(c0);
        vw.y = component_to_float(c1);
        vw.z = (n > 2) ? component_to_float(c2) : pad_reg;
        vw.w = (n > 3) ? component_to_float(c3) : pad_reg;
        if (fmt_reg > vaf_pkg::FMT_HALF) begin
            vw.z = 0;
            vw.w = 0;
        end
        vw.last = lst;
        return vw;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    initial
    begin
        mismatch_count = 0;
        pending_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        vertex_words_t want;
        if (!rst_n) begin
            cnt_reg  <= 3'd4;
            fmt_reg  <= vaf_pkg::FMT_FLOAT;
            norm_reg <= 1'b0;
            pad_reg  <= 32'h3F80_0000;
            expected_vertices.delete();
        end
        else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    vaf_pkg::REG_COUNT:  cnt_reg  <= pwdata[2:0];
                    vaf_pkg::REG_FORMAT: fmt_reg  <= pwdata[3:0];
                    vaf_pkg::REG_NORM:   norm_reg <= pwdata[0];
                    vaf_pkg::REG_PAD:    pad_reg  <= pwdata;
                    default: ;
                endcase
            end
            // accepted input item
            if (in_valid && in_ready)
                expected_vertices.push_back(convert_vertex(raw_comp0, raw_comp1, raw_comp2,
                                                           raw_comp3, last_in));
            // accepted output item
            if (out_valid && out_ready) begin
                if (expected_vertices.size() == 0) begin
                    report_mismatch("unexpected item", out_x, 32'b0);
                end
                else begin
                    want = expected_vertices.pop_front();
                    if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
                    if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
                    if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
                    if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
                    if (last_out !== want.last)
                        report_mismatch("last_out", 32'(last_out), 32'(want.last));
                end
            end
        end
        pending_count <= expected_vertices.size();
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top for the vertex attribute converter: stimulus, config writes and verdict.
`default_nettype none
module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] raw_comp0 = '0;
    logic [63:0] raw_comp1 = '0;
    logic [63:0] raw_comp2 = '0;
    logic [63:0] raw_comp3 = '0;
    logic        last_in = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_x, out_y, out_z, out_w;
    logic        last_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    always #1 clk = ~clk;

    vertex_attribute_to_float uut (.*);

    vaf_checker checker_i (.*);

    // receiver: random stalls plus a single long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 80;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // writes all four registers back to back, entered at a clock edge
    task automatic write_regs(input logic [2:0] cnt, input logic [3:0] fmt, input logic norm,
                              input logic [31:0] pad);
        logic [31:0] vals[4];
        vals[vaf_pkg::REG_COUNT]  = 32'(cnt);
        vals[vaf_pkg::REG_FORMAT] = 32'(fmt);
        vals[vaf_pkg::REG_NORM]   = 32'(norm);
        vals[vaf_pkg::REG_PAD]    = pad;
        for (int i = 0; i < 4; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 4'(i * 4);
            pwdata  <= vals[i];
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering, let every vertex drain, then allow the pipeline to settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0 || in_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_vertex(input logic [63:0] c0, input logic [63:0] c1,
                               input logic [63:0] c2, input logic [63:0] c3, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        raw_comp0 <= c0;
        raw_comp1 <= c1;
        raw_comp2 <= c2;
        raw_comp3 <= c3;
        last_in   <= lst;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // raw component mixing plain noise with boundary and float-shaped patterns
    function automatic logic [63:0] random_component();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0: r = 64'b0;
            1: r = '1;
            2: r = r ^ (64'h8000_0000_8000_8080 << 0);
            3: r = {r[63:16], 1'b1, 15'b0};
            4: r[62:52] = 11'($urandom_range(1023 + 130, 1023 - 160));
            5: r = {r[63:52], 11'($urandom_range(1023 + 127, 1023 - 127)), r[40:29],
                    29'h1000_0000};
            6: r[14:10] = 5'($urandom_range(1) ? 5'h1F : 5'h00);
            7: r = {r[63:32], 32'h7FFF_FFFF ^ {31'b0, r[0]}};
            default: ;
        endcase
        return r;
    endfunction

    initial
    begin
        logic [63:0] doubles[10];
        logic [15:0] halves[7];
        int cnt_opts[7];
        logic [3:0] fmt;
        logic [31:0] pad;

        doubles = '{64'h7FF0_0000_0000_0001, 64'hFFF8_0000_DEAD_BEEF, 64'h7FF0_0000_0000_0000,
                    64'hC7F0_0000_0000_0000, 64'h47EF_FFFF_F000_0000, 64'h3690_0000_0000_0000,
                    64'h3800_0000_1000_0000, 64'h8000_0000_0000_0001, 64'h3FF0_0000_1000_0000,
                    64'h3FF0_0000_3000_0000};
        halves = '{16'h7C00, 16'hFC01, 16'h7E55, 16'h0001, 16'h83FF, 16'h8000, 16'h7BFF};
        cnt_opts = '{2, 3, 4, 0, 1, 5, 7};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: double specials, half specials, integer extremes, an invalid format
        write_regs(3'd4, vaf_pkg::FMT_DOUBLE, 1'b0, 32'h0);
        for (int i = 0; i < 10; i += 4)
            send_vertex(doubles[i], doubles[(i + 1) % 10], doubles[(i + 2) % 10],
                        doubles[(i + 3) % 10], 1'b0);
        send_vertex(doubles[8], doubles[9], doubles[4], doubles[5], 1'b1);
        wait_drained();
        write_regs(3'd4, vaf_pkg::FMT_HALF, 1'b1, 32'hFFFF_FFFF);
        send_vertex(halves[0], halves[1], halves[2], halves[3], 1'b1);
        send_vertex(halves[4], halves[5], halves[6], 64'hFFFF_FFFF_FFFF_3C00, 1'b0);
        wait_drained();
        for (int f = 0; f < 6; f++) begin
            write_regs(3'd4, 4'(f), 1'b1, 32'h0);
            send_vertex(64'h0, '1, 64'h8000_8080, 64'h7FFF_7F7F, 1'b1);
            send_vertex(64'h8000_0000, 64'h7FFF_FFFF, 64'hFFFF_FFFE, 64'h0000_0001, 1'b0);
            wait_drained();
        end
        write_regs(3'd7, 4'd15, 1'b1, 32'h1234_5678);
        send_vertex('1, '1, '1, '1, 1'b1);
        wait_drained();

        // random phases over many register settings
        for (int p = 0; p < 20; p++) begin
            send_idle_pct = (p < 7) ? 21 : (p < 14) ? 84 : 0;
            recv_idle_pct = (p < 7) ? 84 : (p < 14) ? 21 : 0;
            fmt = (p % 10 == 9) ? 4'($urandom_range(15, 9)) : 4'(p % 10);
            case (p % 4)
                0: pad = 32'h0;
                1: pad = '1;
                default: pad = $urandom;
            endcase
            write_regs(3'(cnt_opts[p % 7]), fmt, 1'((p / 2) % 2), pad);
            if (p == 15)
                hold_req <= hold_req + 1;
            for (int i = 0; i < 95; i++)
                send_vertex(random_component(), random_component(), random_component(),
                            random_component(), 1'($urandom_range(1)));
            in_valid <= 1'b0;
            @(posedge clk);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
